>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, switched off while reset is low.
`define CHECK_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("I2C sequencer check failed");

// Same check with a fixed message that names a handshake rule.
`define CHECK_HANDSHAKE(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("I2C sequencer handshake rule broken");

`endif

>>> design/i2cms_pkg.sv
// Types, codes and helper functions of the I2C master bit sequencer.
package i2cms_pkg;

    // Command codes carried in the mode field; also the active command state.
    localparam logic [2:0] CMD_IDLE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // Slot numbers with a special meaning in the command sequences.
    localparam logic [4:0] START_SLOT_SCL_HIGH = 5'd1;
    localparam logic [4:0] START_SLOT_SDA_LOW  = 5'd2;
    localparam logic [4:0] START_SLOT_SCL_LOW  = 5'd3;
    localparam logic [4:0] STOP_SLOT_SDA_HIGH  = 5'd1;
    localparam logic [4:0] WR_SLOT_END         = 5'd24;
    localparam logic [4:0] RD_SLOT_ACK         = 5'd16;
    localparam logic [4:0] RD_SLOT_ACK_CLOCK   = 5'd17;
    localparam logic [4:0] WAIT_SLOT_SCL_HIGH  = 5'd1;
    localparam logic [4:0] WAIT_SLOT_POLL      = 5'd2;
    localparam logic [4:0] WAIT_SLOT_STOP      = 5'd3;
    localparam logic [4:0] WAIT_SLOT_STOP_SDA  = 5'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_fail;
    } out_item_t;

    // Position of a write slot within its bit (slot mod 3), valid for slots below 24.
    // The quotient comes from a multiply by 11 and a shift by 5.
    function automatic logic [1:0] wr_slot_phase(input logic [4:0] slot);
        logic [8:0] prod;
        logic [3:0] quot;
        logic [4:0] rem;
        prod = {4'd0, slot} * 9'd11;
        quot = prod[8:5];
        rem  = slot - (5'({1'b0, quot}) + 5'({quot, 1'b0}));
        return rem[1:0];
    endfunction

endpackage

>>> design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: drives SCL and SDA from commands, one tick per item.
//
// Usage: each input item is one timing tick. It carries the sampled SDA level and,
// while the sequencer is idle, may carry a command (start, stop, write byte, read
// byte with ACK or NACK, wait for ACK). A command given while busy is ignored.
// Each delay slot but the wait-ACK poll lasts phase_ticks ticks (zero counts as one).
// Each accepted item yields exactly one result item: the pin levels after that
// tick, busy and done flags, the byte of the last read and the wait-ACK status.
// The result of an accepted item is registered and shown on the output in the
// cycle after it is taken. Throughput is one item per cycle while the receiver does
// not stall; the whole step is a short compare/increment path from the input port
// into the state and the output register, so a new tick can be taken every cycle.
// When the receiver stalls, the output register holds its item and the input side
// stalls in the same cycle only while that item is still waiting; as soon as the
// result is taken a new item enters.
// Reset leaves the sequencer idle with SCL high and SDA high and driven,
// phase_ticks at 1 and ack_timeout at 250. Configuration writes belong to idle
// periods.
module i2c_master_bit_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  i2cms_pkg::in_item_t                  in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output i2cms_pkg::out_item_t                 out_item,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [15:0] phase_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    // Sequencer state.
    logic [2:0]  cmd_reg,   cmd_next;
    logic [4:0]  step_reg,  step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] div_reg,   div_next;
    logic [7:0]  poll_reg,  poll_next;
    logic        ackc_reg,  ackc_next;
    logic        scl_reg,   scl_next;
    logic        sda_reg,   sda_next;
    logic        drv_reg,   drv_next;
    logic        fail_reg,  fail_next;
    logic [7:0]  rx_reg,    rx_next;
    logic        done_next;

    // Output register.
    logic                 out_valid_reg;
    i2cms_pkg::out_item_t out_item_reg;

    logic        accept;
    logic [15:0] phase;
    logic        do_enter;
    logic [4:0]  enter_slot;
    logic        do_poll;
    logic [1:0]  wr_phase;

    // The input side waits only while a finished result is still held back.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign phase = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cms_pkg::PHASE_TICKS_RESET;
            ack_timeout_reg <= i2cms_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                i2cms_pkg::CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                i2cms_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One tick of the sequencer: decide whether a command starts, a slot is still
    // counting, the wait-ACK poll runs, or the next slot is entered.
    always_comb
    begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        poll_next  = poll_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        do_enter   = 1'b0;
        enter_slot = step_reg + 5'd1;
        do_poll    = 1'b0;

        if (cmd_reg == i2cms_pkg::CMD_IDLE)
        begin
            if (in_item.mode >= i2cms_pkg::CMD_START &&
                in_item.mode <= i2cms_pkg::CMD_WAIT_ACK)
            begin
                cmd_next   = in_item.mode;
                shift_next = (in_item.mode == i2cms_pkg::CMD_WRITE) ? in_item.tx_byte : 8'd0;
                ackc_next  = in_item.ack_after_read;
                poll_next  = 8'd0;
                do_enter   = 1'b1;
                enter_slot = 5'd0;
            end
        end
        else if (cmd_reg == i2cms_pkg::CMD_WAIT_ACK && step_reg == i2cms_pkg::WAIT_SLOT_POLL)
        begin
            do_poll = 1'b1;
        end
        else if (div_reg < phase)
        begin
            div_next = div_reg + 16'd1;
        end
        else
        begin
            do_enter = 1'b1;
        end

        wr_phase = i2cms_pkg::wr_slot_phase(enter_slot);

        if (do_enter)
        begin
            step_next = enter_slot;
            div_next  = 16'd1;
            case (cmd_next)
                i2cms_pkg::CMD_START:
                begin
                    if (enter_slot == 5'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else if (enter_slot == i2cms_pkg::START_SLOT_SCL_HIGH)
                        scl_next = 1'b1;
                    else if (enter_slot == i2cms_pkg::START_SLOT_SDA_LOW)
                        sda_next = 1'b0;
                    else if (enter_slot == i2cms_pkg::START_SLOT_SCL_LOW)
                        scl_next = 1'b0;
                    else
                        done_next = 1'b1;
                end
                i2cms_pkg::CMD_STOP:
                begin
                    if (enter_slot == 5'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    else if (enter_slot == i2cms_pkg::STOP_SLOT_SDA_HIGH)
                        sda_next = 1'b1;
                    else
                        done_next = 1'b1;
                end
                i2cms_pkg::CMD_WRITE:
                begin
                    // Three slots per bit: set data with SCL low, SCL high, SCL low.
                    if (enter_slot >= i2cms_pkg::WR_SLOT_END)
                        done_next = 1'b1;
                    else if (wr_phase == 2'd0)
                    begin
                        drv_next   = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = shift_next[7];
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                    else
                        scl_next = (wr_phase == 2'd1);
                end
                i2cms_pkg::CMD_READ:
                begin
                    // Two slots per bit; SDA is sampled on the tick SCL rises.
                    if (enter_slot < i2cms_pkg::RD_SLOT_ACK)
                    begin
                        if (!enter_slot[0])
                        begin
                            scl_next = 1'b0;
                            drv_next = 1'b0;
                            sda_next = 1'b1;
                        end
                        else
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_next[6:0], in_item.sda_in};
                        end
                    end
                    else if (enter_slot == i2cms_pkg::RD_SLOT_ACK)
                    begin
                        scl_next = 1'b0;
                        drv_next = 1'b1;
                        sda_next = !ackc_next;
                    end
                    else if (enter_slot == i2cms_pkg::RD_SLOT_ACK_CLOCK)
                        scl_next = 1'b1;
                    else
                    begin
                        scl_next  = 1'b0;
                        rx_next   = shift_next;
                        done_next = 1'b1;
                    end
                end
                i2cms_pkg::CMD_WAIT_ACK:
                begin
                    if (enter_slot == 5'd0)
                    begin
                        drv_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (enter_slot == i2cms_pkg::WAIT_SLOT_SCL_HIGH)
                        scl_next = 1'b1;
                    else if (enter_slot == i2cms_pkg::WAIT_SLOT_POLL)
                        do_poll = 1'b1;
                    else if (enter_slot == i2cms_pkg::WAIT_SLOT_STOP_SDA)
                        sda_next = 1'b1;
                    else
                    begin
                        fail_next = 1'b1;
                        done_next = 1'b1;
                    end
                end
                default:
                    done_next = 1'b1;
            endcase
        end

        // Wait-ACK poll: a low SDA finishes, a high one counts until the limit,
        // and at the limit the stop sequence begins.
        if (do_poll)
        begin
            if (!in_item.sda_in)
            begin
                scl_next  = 1'b0;
                fail_next = 1'b0;
                done_next = 1'b1;
            end
            else if (poll_reg >= ack_timeout_reg)
            begin
                step_next = i2cms_pkg::WAIT_SLOT_STOP;
                div_next  = 16'd1;
                drv_next  = 1'b1;
                sda_next  = 1'b0;
                scl_next  = 1'b1;
            end
            else
                poll_next = poll_reg + 8'd1;
        end

        if (done_next)
        begin
            cmd_next  = i2cms_pkg::CMD_IDLE;
            step_next = 5'd0;
            div_next  = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= i2cms_pkg::CMD_IDLE;
            step_reg  <= 5'd0;
            shift_reg <= 8'd0;
            div_reg   <= 16'd0;
            poll_reg  <= 8'd0;
            ackc_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            fail_reg  <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (accept)
        begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            shift_reg <= shift_next;
            div_reg   <= div_next;
            poll_reg  <= poll_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            fail_reg  <= fail_next;
            rx_reg    <= rx_next;
        end
    end

    // Result register: filled on every accepted tick, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg.scl_level <= scl_next;
            out_item_reg.sda_level <= sda_next;
            out_item_reg.sda_drive <= drv_next;
            out_item_reg.busy_res  <= (cmd_next != i2cms_pkg::CMD_IDLE);
            out_item_reg.done_res  <= done_next;
            out_item_reg.rx_byte   <= rx_next;
            out_item_reg.ack_fail  <= fail_next;
        end
    end

endmodule

>>> design/i2cms_checker.sv
// Port-level checks of the I2C master bit sequencer, bound to its top level.
`include "assert_macros.svh"

module i2cms_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input i2cms_pkg::out_item_t             out_item
);

    // A result that waits on a stalled receiver stays as it is.
    `CHECK_HANDSHAKE(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item))

    // Every accepted tick leaves a result item in the output register.
    `CHECK_PROP(a_accept_gives_result, clk, rst_n, in_valid && !in_stall |=> out_valid)

    // The input side only waits behind a pending result.
    `CHECK_PROP(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid)

    // A finishing tick never reports the command as still running.
    `CHECK_PROP(a_done_not_busy, clk, rst_n, out_valid |-> !(out_item.done_res && out_item.busy_res))

    // A released SDA line always reads as high in the result.
    `CHECK_PROP(a_release_high, clk, rst_n, out_valid && !out_item.sda_drive |-> out_item.sda_level)

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);
